>>> src/assert_macros.svh
// Assertion macros shared by the frame decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/crcfd_pkg.sv
// Shared constants, types and functions of the measurement frame decoder.
package crcfd_pkg;

	localparam int unsigned WORDS = 3;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [31:0] TEMP_SCALE = 32'd17500;
	localparam logic [31:0] HUM_SCALE = 32'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [16:0] FULL_SCALE = 17'd65535;

	// Everything the result stage needs once the ninth byte of a frame is in.
	typedef struct packed {
		logic [2:0]  fail_mask;
		logic [15:0] co2_word;
		logic [15:0] temp_word;
		logic [15:0] hum_word;
	} frame_done_t;

	// CRC-8 of one byte, MSB first, no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// Floor of x / 65535 for x below 2^31. Since x = q*65535 + (q + lo) with q = x >> 16,
	// one compare against the divisor fixes the quotient.
	function automatic logic [15:0] div_full_scale(input logic [31:0] x);
		logic [15:0] q0;
		logic [16:0] r;
		q0 = x[31:16];
		r = {1'b0, x[15:0]} + {1'b0, q0};
		return (r >= FULL_SCALE) ? q0 + 16'd1 : q0;
	endfunction

endpackage

>>> src/crcfd_frame.sv
// Input register and byte-by-byte frame tracking with per-word CRC check.
`include "assert_macros.svh"

module crcfd_frame (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               data_byte,
	input  logic                     frame_start,
	output logic                     done_valid,
	input  logic                     done_ready,
	output crcfd_pkg::frame_done_t   done
);

	typedef enum logic [1:0] {
		SUB_HIGH,
		SUB_LOW,
		SUB_CRC
	} sub_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	sub_t        sub_q;
	logic [1:0]  word_q;
	logic [7:0]  crc_q;
	logic [7:0]  hold_q;
	logic [2:0]  fail_q;
	logic [15:0] word_store_q [crcfd_pkg::WORDS];

	sub_t        sub_eff, sub_n;
	logic [1:0]  word_eff, word_n;
	logic [7:0]  crc_eff, crc_n;
	logic [2:0]  fail_eff, fail_n;
	logic [7:0]  hold_n;
	logic        wr_en;
	logic        last;
	logic        take;

	// A start mark drops whatever partial frame is in progress.
	always_comb begin
		sub_eff  = start_s1 ? SUB_HIGH : sub_q;
		word_eff = start_s1 ? 2'd0 : word_q;
		crc_eff  = start_s1 ? crcfd_pkg::CRC_INIT : crc_q;
		fail_eff = start_s1 ? 3'd0 : fail_q;

		crc_n  = crc_eff;
		hold_n = hold_q;
		fail_n = fail_eff;
		wr_en  = 1'b0;
		sub_n  = sub_eff;
		word_n = word_eff;

		unique case (sub_eff)
			SUB_HIGH: begin
				crc_n  = crcfd_pkg::crc8_byte(crcfd_pkg::CRC_INIT, byte_s1);
				hold_n = byte_s1;
				sub_n  = SUB_LOW;
			end
			SUB_LOW: begin
				crc_n = crcfd_pkg::crc8_byte(crc_eff, byte_s1);
				wr_en = 1'b1;
				sub_n = SUB_CRC;
			end
			SUB_CRC: begin
				if (crc_eff != byte_s1) begin
					fail_n = fail_eff | (3'b001 << word_eff);
				end
				crc_n  = crcfd_pkg::CRC_INIT;
				sub_n  = SUB_HIGH;
				word_n = word_eff + 2'd1;
			end
			default: begin
				sub_n = SUB_HIGH;
			end
		endcase

		last = (sub_eff == SUB_CRC) && (word_eff == 2'(crcfd_pkg::WORDS - 1));
	end

	// The last byte of a frame waits here while the result stage is not ready.
	assign take     = valid_s1 && (!last || done_ready);
	assign in_ready = !valid_s1 || take;

	assign done_valid       = valid_s1 && last;
	assign done.fail_mask   = fail_n;
	assign done.co2_word    = word_store_q[0];
	assign done.temp_word   = word_store_q[1];
	assign done.hum_word    = word_store_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sub_q    <= SUB_HIGH;
			word_q   <= 2'd0;
			crc_q    <= crcfd_pkg::CRC_INIT;
			fail_q   <= 3'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (take) begin
				if (last) begin
					sub_q  <= SUB_HIGH;
					word_q <= 2'd0;
					crc_q  <= crcfd_pkg::CRC_INIT;
					fail_q <= 3'd0;
				end else begin
					sub_q  <= sub_n;
					word_q <= word_n;
					crc_q  <= crc_n;
					fail_q <= fail_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= frame_start;
		end
		if (take) begin
			hold_q <= hold_n;
		end
		for (int i = 0; i < crcfd_pkg::WORDS; i++) begin
			if (take && wr_en && (word_eff == 2'(i))) begin
				word_store_q[i] <= {hold_q, byte_s1};
			end
		end
	end

	`ASSERT_ALWAYS(a_word_range, word_q != 2'd3, "word index out of range")
	`ASSERT_NEXT(a_frame_end_clears, take && last,
		word_q == 2'd0 && sub_q == SUB_HIGH && crc_q == crcfd_pkg::CRC_INIT && fail_q == 3'd0,
		"frame state not cleared after last byte")
	`ASSERT_NEXT(a_done_holds, done_valid && !done_ready,
		done_valid && $stable(done.fail_mask), "stalled frame result changed")
	`ASSERT_IMPLIES(a_stall_blocks_input, valid_s1 && !take, !in_ready,
		"input taken while held byte is stalled")

endmodule

>>> src/crcfd_result.sv
// Value scaling and the output result register.
`include "assert_macros.svh"

module crcfd_result (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     done_valid,
	output logic                     done_ready,
	input  crcfd_pkg::frame_done_t   done,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [47:0]              m_axis_tdata,
	output logic                     m_axis_tuser
);

	logic        tvalid_q;
	logic [47:0] tdata_q;
	logic        tuser_q;

	logic        ok;
	logic [31:0] temp_prod;
	logic [31:0] hum_prod;
	logic [15:0] temp_raw;
	logic [15:0] hum_raw;
	logic [14:0] temp_centi;
	logic [13:0] hum_centi;
	logic [15:0] co2_ppm;
	logic        load;

	// Scale by the full-range factor, then divide by 65535 with one correction step; a failed frame gives zeros.
	always_comb begin
		ok         = (done.fail_mask == 3'd0);
		temp_prod  = crcfd_pkg::TEMP_SCALE * {16'd0, done.temp_word};
		hum_prod   = crcfd_pkg::HUM_SCALE * {16'd0, done.hum_word};
		temp_raw   = crcfd_pkg::div_full_scale(temp_prod);
		hum_raw    = crcfd_pkg::div_full_scale(hum_prod);
		temp_centi = ok ? (temp_raw[14:0] - crcfd_pkg::TEMP_OFFSET) : 15'd0;
		hum_centi  = ok ? hum_raw[13:0] : 14'd0;
		co2_ppm    = ok ? done.co2_word : 16'd0;
	end

	assign done_ready = !tvalid_q || m_axis_tready;
	assign load       = done_valid && done_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= {hum_centi, temp_centi, co2_ppm, done.fail_mask};
			tuser_q <= ok;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

	`ASSERT_IMPLIES(a_flag_matches_mask, tvalid_q,
		tuser_q == (tdata_q[2:0] == 3'd0), "valid flag disagrees with fail mask")
	`ASSERT_IMPLIES(a_invalid_zero, tvalid_q && !tuser_q,
		tdata_q[47:3] == 45'd0, "failed frame carries nonzero values")
	`ASSERT_IMPLIES(a_hum_range, tvalid_q, tdata_q[47:34] <= 14'd10000,
		"humidity above full scale")
	`ASSERT_NEXT(a_result_held, tvalid_q && !m_axis_tready,
		tvalid_q && $stable(tdata_q), "stalled result changed")

endmodule

>>> src/crc_checked_measurement_frame_decoder.sv
// Top level of the CRC-checked measurement frame decoder.
// A result is registered once the ninth byte is taken from the input register.
// Throughput: one byte per cycle unless held; input and result registers part the sides.
// Only the ninth byte of a frame waits in the input register while a result is unaccepted.
// Reset (arst_n low) clears the frame position, running CRC, fail bits and both valid flags.
// Word storage has no reset; every word is written before the frame end reads it.
module crc_checked_measurement_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Input byte stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	// Result stream, one item per complete frame.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [2:0] crc_fail_mask, [18:3] co2_ppm,
	                                    // [33:19] temperature_centi, [47:34] humidity_centi
	output logic        m_axis_tuser    // [0] valid_res
);

	logic                   done_valid;
	logic                   done_ready;
	crcfd_pkg::frame_done_t done;

	// Byte tracking: position in the frame, per-word CRC and the received words.
	crcfd_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.data_byte   (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.done_valid  (done_valid),
		.done_ready  (done_ready),
		.done        (done)
	);

	// Scaling of the temperature and humidity words and the result register.
	crcfd_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.done_valid    (done_valid),
		.done_ready    (done_ready),
		.done          (done),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
